### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro takes a label, clock, active-low reset, property (or antecedent and consequent) and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at a clock edge requires consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rssmc_pkg.sv
// Package for the range sample sequencer: item kinds, phase codes,
// register indexes, reset defaults, filter result struct and median helper.
package rssmc_pkg;

	localparam int unsigned DistW  = 16;
	localparam int unsigned TickW  = 16;
	localparam int unsigned CountW = 8;
	localparam int unsigned IdxW   = 2;
	localparam int unsigned CfgW   = 16;

	localparam logic [TickW-1:0]  PeriodDefault    = 16'd50;
	localparam logic [DistW-1:0]  ThresholdDefault = 16'd30;
	localparam logic [CountW-1:0] RolloutDefault   = 8'd6;
	localparam logic [TickW-1:0]  WarmupDefault    = 16'd10;
	localparam logic [CountW-1:0] CountMax         = 8'd255;

	typedef enum logic [1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_READING = 2'd1,
		FUNC_BUS_ERR = 2'd2,
		FUNC_UNUSED  = 2'd3
	} func_t;

	typedef enum logic [IdxW-1:0] {
		REG_SAMPLE_PERIOD = 2'd0,
		REG_THRESHOLD     = 2'd1,
		REG_ROLLOUT_LIMIT = 2'd2,
		REG_WARMUP_TICKS  = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_ROLLOUT = 5'b00010,
		PH_WARMUP  = 5'b00100,
		PH_SAMPLE  = 5'b01000,
		PH_ERROR   = 5'b10000
	} phase_t;

	// Next filter state produced for one sampled reading.
	typedef struct packed {
		logic [2:0][DistW-1:0] window;
		logic [1:0]            pos;
		logic                  filled;
		logic [DistW-1:0]      filtered;
		logic                  changing;
		logic                  ev;
		logic                  ev_kind;
		logic [DistW-1:0]      ev_dist;
	} filt_res_t;

	function automatic logic [DistW-1:0] mid3(input logic [DistW-1:0] a,
			input logic [DistW-1:0] b, input logic [DistW-1:0] c);
		logic [DistW-1:0] r;
		if (a > b) begin
			if (b > c) r = b;
			else r = (a > c) ? c : a;
		end else begin
			if (b > c) r = (a > c) ? a : c;
			else r = b;
		end
		return r;
	endfunction

endpackage

### rtl/rssmc_in_if.sv
// Channel interfaces of the range sample sequencer: input items, results
// and configuration writes. Depends on rssmc_pkg for field widths.
interface rssmc_in_if import rssmc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       func;
	logic [DistW-1:0] distance;
	modport source (output valid, func, distance, input ready);
	modport sink   (input valid, func, distance, output ready);
endinterface

interface rssmc_out_if import rssmc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             request_reading;
	logic             sensor_power;
	logic             event_valid;
	logic             event_kind;
	logic [DistW-1:0] event_distance;
	logic [DistW-1:0] filtered_distance;
	logic             change_flag;
	logic             sampling_error;
	modport source (output valid, request_reading, sensor_power, event_valid, event_kind,
		event_distance, filtered_distance, change_flag, sampling_error, input ready);
	modport sink (input valid, request_reading, sensor_power, event_valid, event_kind,
		event_distance, filtered_distance, change_flag, sampling_error, output ready);
endinterface

interface rssmc_cfg_if import rssmc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IdxW-1:0] index;
	logic [CfgW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rssmc_filter.sv
// Median-of-three window update and change detection for one reading.
// Purely combinational; depends on rssmc_pkg for mid3 and filt_res_t.
module rssmc_filter import rssmc_pkg::*; (
	input  logic [2:0][DistW-1:0] window,
	input  logic [1:0]            pos,
	input  logic                  filled,
	input  logic [DistW-1:0]      filtered,
	input  logic                  changing,
	input  logic [DistW-1:0]      threshold,
	input  logic [DistW-1:0]      distance,
	output filt_res_t             res
);

	logic [DistW-1:0]      d;
	logic [1:0]            wpos;
	logic [2:0][DistW-1:0] win_n;
	logic                  wrap;
	logic [DistW-1:0]      med;
	logic [DistW-1:0]      base;
	logic [DistW-1:0]      diff;
	logic                  filled_n;

	always_comb begin
		// A zero reading stands in for the last filtered value.
		d    = (distance == '0) ? filtered : distance;
		wpos = (pos > 2'd2) ? 2'd0 : pos;
		win_n = window;
		win_n[wpos] = d;
		wrap = (wpos == 2'd2);
		med  = mid3(win_n[0], win_n[1], win_n[2]);
		filled_n = filled | wrap;
		// The first full window seeds the filtered value before comparison.
		base = (wrap && !filled) ? med : filtered;
		diff = (med > base) ? (med - base) : (base - med);

		res.window   = win_n;
		res.pos      = wrap ? 2'd0 : (wpos + 2'd1);
		res.filled   = filled_n;
		res.filtered = base;
		res.changing = changing;
		res.ev       = 1'b0;
		res.ev_kind  = 1'b0;
		res.ev_dist  = '0;
		if (filled_n) begin
			res.filtered = med;
			if (diff > threshold) begin
				res.changing = 1'b1;
				if (!changing) begin
					res.ev      = 1'b1;
					res.ev_kind = 1'b0;
					res.ev_dist = med;
				end
			end else begin
				res.changing = 1'b0;
				if (changing) begin
					res.ev      = 1'b1;
					res.ev_kind = 1'b1;
					res.ev_dist = med;
				end
			end
		end
	end

endmodule

### rtl/range_sample_sequencer_median_change_core.sv
// An accepted item is loaded into the input register, its result into the result
// register once the output is free. Throughput: one item per cycle while the output
// is not stalled; the phase and filter update is one pass of logic between them.
// Reset (arst_n low) clears all sequencer and filter state and restores the
// register defaults; configuration writes are taken in every cycle.
// Depends on rssmc_pkg, the channel interfaces and rssmc_filter.
module range_sample_sequencer_median_change_core import rssmc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rssmc_in_if.sink     sample_in,
	rssmc_out_if.source  result_out,
	rssmc_cfg_if.sink    cfg
);

	// Configuration registers.
	logic [TickW-1:0]  period_q;
	logic [DistW-1:0]  threshold_q;
	logic [CountW-1:0] rollout_q;
	logic [TickW-1:0]  warmup_q;

	// Sequencer and filter state.
	phase_t                phase_q, phase_n;
	logic [TickW-1:0]      tick_q, tick_n, tick_inc;
	logic [CountW-1:0]     count_q, count_n;
	logic [2:0][DistW-1:0] window_q;
	logic [1:0]            pos_q;
	logic                  filled_q;
	logic [DistW-1:0]      filtered_q;
	logic                  changing_q;
	logic                  error_q, error_n;
	logic                  power_q, power_n;
	logic                  req_n;
	logic                  sample_rd;

	// Input stage and result register.
	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [DistW-1:0]  dist_s1;
	logic              out_valid_q;
	logic              out_free;
	logic              advance;
	filt_res_t         filt;

	assign out_free        = !out_valid_q || result_out.ready;
	assign advance         = valid_s1 && out_free;
	assign sample_in.ready = !valid_s1 || out_free;
	assign cfg.ready       = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PeriodDefault;
			threshold_q <= ThresholdDefault;
			rollout_q   <= RolloutDefault;
			warmup_q    <= WarmupDefault;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_SAMPLE_PERIOD: period_q    <= cfg.data;
				REG_THRESHOLD:     threshold_q <= cfg.data;
				REG_ROLLOUT_LIMIT: rollout_q   <= cfg.data[CountW-1:0];
				REG_WARMUP_TICKS:  warmup_q    <= cfg.data;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.valid && sample_in.ready) begin
			func_s1 <= sample_in.func;
			dist_s1 <= sample_in.distance;
		end
	end

	rssmc_filter u_filter (
		.window    (window_q),
		.pos       (pos_q),
		.filled    (filled_q),
		.filtered  (filtered_q),
		.changing  (changing_q),
		.threshold (threshold_q),
		.distance  (dist_s1),
		.res       (filt)
	);

	assign tick_inc = tick_q + 1'b1;

	// Phase sequencing for the item held in the input stage.
	always_comb begin
		phase_n   = phase_q;
		tick_n    = tick_q;
		count_n   = count_q;
		error_n   = error_q;
		power_n   = power_q;
		req_n     = 1'b0;
		sample_rd = 1'b0;
		unique case (func_t'(func_s1))
			FUNC_TICK: begin
				tick_n = tick_inc;
				if (tick_inc >= period_q) begin
					tick_n  = '0;
					error_n = (phase_q != PH_IDLE);
					phase_n = PH_ROLLOUT;
					count_n = '0;
					power_n = 1'b1;
				end
				unique case (phase_n)
					PH_ROLLOUT: begin
						if (count_n >= rollout_q) phase_n = PH_SAMPLE;
						req_n = 1'b1;
					end
					PH_WARMUP: begin
						if (tick_n >= warmup_q) phase_n = PH_SAMPLE;
					end
					PH_SAMPLE: req_n = 1'b1;
					PH_IDLE, PH_ERROR: ;
					default: ;
				endcase
			end
			FUNC_READING: begin
				if (phase_q == PH_ROLLOUT && dist_s1 != '0) phase_n = PH_WARMUP;
				if (phase_q == PH_SAMPLE) begin
					sample_rd = 1'b1;
					phase_n   = PH_IDLE;
					power_n   = 1'b0;
					error_n   = 1'b0;
				end
				if (count_q < CountMax) count_n = count_q + 1'b1;
			end
			FUNC_BUS_ERR: phase_n = PH_ERROR;
			FUNC_UNUSED: ;
		endcase
	end

	// State update and result register, one transaction per cycle while the output is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			count_q     <= '0;
			window_q    <= '0;
			pos_q       <= '0;
			filled_q    <= 1'b0;
			filtered_q  <= '0;
			changing_q  <= 1'b0;
			error_q     <= 1'b0;
			power_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) out_valid_q <= valid_s1;
			if (advance) begin
				phase_q <= phase_n;
				tick_q  <= tick_n;
				count_q <= count_n;
				error_q <= error_n;
				power_q <= power_n;
				if (sample_rd) begin
					window_q   <= filt.window;
					pos_q      <= filt.pos;
					filled_q   <= filt.filled;
					filtered_q <= filt.filtered;
					changing_q <= filt.changing;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_out.request_reading   <= req_n;
			result_out.sensor_power      <= power_n;
			result_out.event_valid       <= sample_rd & filt.ev;
			result_out.event_kind        <= sample_rd & filt.ev_kind;
			result_out.event_distance    <= sample_rd ? filt.ev_dist : '0;
			result_out.filtered_distance <= sample_rd ? filt.filtered : filtered_q;
			result_out.change_flag       <= sample_rd ? filt.changing : changing_q;
			result_out.sampling_error    <= error_n;
		end
	end

	assign result_out.valid = out_valid_q;

endmodule

### rtl/rssmc_checker.sv
// Port-level checker for the range sample sequencer core, with its bind.
// Depends on rssmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rssmc_checker import rssmc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             request_reading,
	input logic             sensor_power,
	input logic             event_valid,
	input logic             event_kind,
	input logic [DistW-1:0] event_distance,
	input logic [DistW-1:0] filtered_distance,
	input logic             change_flag
);

	// A stalled result stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// An event leaves the change flag in the state that the event names.
	`ASSERT_ALWAYS(a_ev_flag, clk, arst_n, !(out_valid && event_valid) || (change_flag != event_kind), "event kind disagrees with change flag")

	// An event carries the new filtered distance.
	`ASSERT_ALWAYS(a_ev_dist, clk, arst_n, !(out_valid && event_valid) || (event_distance == filtered_distance), "event distance is not the filtered distance")

	// Without an event the event fields are zero.
	`ASSERT_ALWAYS(a_no_ev, clk, arst_n, !(out_valid && !event_valid) || (!event_kind && event_distance == '0), "event fields set without an event")

	// Readings are only requested while the sensor is powered.
	`ASSERT_ALWAYS(a_req_pwr, clk, arst_n, !(out_valid && request_reading) || sensor_power, "reading requested with sensor off")

endmodule

bind range_sample_sequencer_median_change_core rssmc_checker u_rssmc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (result_out.valid),
	.out_ready         (result_out.ready),
	.request_reading   (result_out.request_reading),
	.sensor_power      (result_out.sensor_power),
	.event_valid       (result_out.event_valid),
	.event_kind        (result_out.event_kind),
	.event_distance    (result_out.event_distance),
	.filtered_distance (result_out.filtered_distance),
	.change_flag       (result_out.change_flag)
);
